// ----- sv/iawd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawd_pkg
// shared commands, status codes and widths of the integer alu with divide
// ----------------------------------------------------------------------------
package iawd_pkg;

    localparam int IawdDataWidth = 64;
    localparam int CmdWidth      = 5;
    localparam int StatusWidth   = 2;
    localparam int PortWidth     = 64;

    localparam logic [CmdWidth-1:0] CMD_ADD  = 5'd0;
    localparam logic [CmdWidth-1:0] CMD_SUB  = 5'd1;
    localparam logic [CmdWidth-1:0] CMD_MUL  = 5'd2;
    localparam logic [CmdWidth-1:0] CMD_DIV  = 5'd3;
    localparam logic [CmdWidth-1:0] CMD_MOD  = 5'd4;
    localparam logic [CmdWidth-1:0] CMD_EQ   = 5'd5;
    localparam logic [CmdWidth-1:0] CMD_NE   = 5'd6;
    localparam logic [CmdWidth-1:0] CMD_LE   = 5'd7;
    localparam logic [CmdWidth-1:0] CMD_GE   = 5'd8;
    localparam logic [CmdWidth-1:0] CMD_LT   = 5'd9;
    localparam logic [CmdWidth-1:0] CMD_GT   = 5'd10;
    localparam logic [CmdWidth-1:0] CMD_NEG  = 5'd11;
    localparam logic [CmdWidth-1:0] CMD_NOT  = 5'd12;
    localparam logic [CmdWidth-1:0] CMD_AND  = 5'd13;
    localparam logic [CmdWidth-1:0] CMD_OR   = 5'd14;
    localparam logic [CmdWidth-1:0] CMD_XOR  = 5'd15;
    localparam logic [CmdWidth-1:0] CMD_CPL  = 5'd16;
    localparam logic [CmdWidth-1:0] CMD_SHL  = 5'd17;
    localparam logic [CmdWidth-1:0] CMD_SHR  = 5'd18;

    localparam logic [StatusWidth-1:0] ST_OK      = 2'd0;
    localparam logic [StatusWidth-1:0] ST_DIV_ZER = 2'd1;
    localparam logic [StatusWidth-1:0] ST_MOD_ZER = 2'd2;

endpackage
`default_nettype wire

// ----- sv/iawd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawd_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface iawd_cmd_if
    import iawd_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [CmdWidth-1:0]    command;
    logic [PortWidth-1:0]   operand_a;
    logic [PortWidth-1:0]   operand_b;
    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface iawd_res_if
    import iawd_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [PortWidth-1:0]   result;
    logic [StatusWidth-1:0] status;
    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface
`default_nettype wire

// ----- sv/integer_alu_with_divide.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_with_divide
// pipelined signed integer alu with add, subtract, multiply, divide, modulo, compare, logic and shift
// ----------------------------------------------------------------------------
// channel | dir | fields
// cmd     | in  | command, operand_a, operand_b
// res     | out | result, status
//
// one beat per cycle while the output is not stalled; after the command beat is taken, the result
// beat passes the decode register, one divider stage per four quotient bits, then the
// fix-up and output register; the multiplier spans three stages
// whole pipeline advances together; a stalled output freezes every stage
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module integer_alu_with_divide
    import iawd_pkg::*;
#(
    parameter int DATA_WIDTH = IawdDataWidth
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    iawd_cmd_if.sink   cmd,
    iawd_res_if.source res
);

    localparam int W          = DATA_WIDTH;
    localparam int STEPS      = 4;
    localparam int NDIV       = (W + STEPS - 1) / STEPS;
    localparam int LAST_STEPS = W - (NDIV - 1) * STEPS;
    localparam int DEPTH      = NDIV + 1;
    localparam int SHW        = $clog2(W);
    localparam int ML         = W / 2;
    localparam int MH         = W - ML;

    typedef struct packed {
        logic                   is_div;
        logic                   neg_res;
        logic                   zero_dvs;
        logic [CmdWidth-1:0]    command;
        logic [W-1:0]           other;
    } side_t;

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic             out_vld_reg;

    assign adv       = !out_vld_reg || res.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[DEPTH-2:0], cmd.valid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // stage 0: operand decode and the results that need neither divider nor multiplier
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] ux;
    logic [W-1:0] uy;
    logic [W-1:0] simple;
    logic         slt_xy;
    logic         slt_yx;
    logic         sh_ok;

    assign x      = cmd.operand_a[W-1:0];
    assign y      = cmd.operand_b[W-1:0];
    assign ux     = x[W-1] ? (W'(0) - x) : x;
    assign uy     = y[W-1] ? (W'(0) - y) : y;
    assign slt_xy = $signed(x) < $signed(y);
    assign slt_yx = $signed(y) < $signed(x);
    assign sh_ok  = (y < W'(W));

    always_comb
    begin
        case (cmd.command)
            CMD_ADD: simple = x + y;
            CMD_SUB: simple = x - y;
            CMD_EQ:  simple = W'(x == y);
            CMD_NE:  simple = W'(x != y);
            CMD_LE:  simple = W'(!slt_yx);
            CMD_GE:  simple = W'(!slt_xy);
            CMD_LT:  simple = W'(slt_xy);
            CMD_GT:  simple = W'(slt_yx);
            CMD_NEG: simple = W'(0) - x;
            CMD_NOT: simple = W'(x == '0);
            CMD_AND: simple = x & y;
            CMD_OR:  simple = x | y;
            CMD_XOR: simple = x ^ y;
            CMD_CPL: simple = ~x;
            CMD_SHL: simple = sh_ok ? (x << y[SHW-1:0]) : '0;
            CMD_SHR: simple = sh_ok ? (x >> y[SHW-1:0]) : '0;
            default: simple = '0;
        endcase
    end

    side_t side_in;
    always_comb
    begin
        side_in.command  = cmd.command;
        side_in.is_div   = (cmd.command == CMD_DIV) || (cmd.command == CMD_MOD);
        side_in.zero_dvs = (y == '0);
        side_in.neg_res  = (cmd.command == CMD_DIV) ? (x[W-1] ^ y[W-1]) : x[W-1];
        side_in.other    = simple;
    end

    // multiplier: operands registered, half-width partial products, then the sum
    logic [W-1:0]    mx_reg;
    logic [W-1:0]    my_reg;
    logic [2*ML-1:0] pp_ll_reg;
    logic [MH-1:0]   pp_lh_reg;
    logic [MH-1:0]   pp_hl_reg;
    logic [W-1:0]    mul_sum;

    assign mul_sum = W'(pp_ll_reg) + {pp_lh_reg + pp_hl_reg, ML'(0)};

    // side band travels alongside the divider
    side_t side_reg [NDIV+1];
    side_t side_m;
    logic [W-1:0] rem_p [NDIV+1];
    logic [W-1:0] quo_p [NDIV+1];
    logic [W-1:0] dvs_p [NDIV+1];

    always_comb
    begin
        side_m = side_reg[1];
        if (side_reg[1].command == CMD_MUL)
        begin
            side_m.other = mul_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg      <= x;
            my_reg      <= y;
            pp_ll_reg   <= {{ML{1'b0}}, mx_reg[ML-1:0]} * {{ML{1'b0}}, my_reg[ML-1:0]};
            pp_lh_reg   <= MH'(mx_reg[ML-1:0]) * my_reg[W-1:ML];
            pp_hl_reg   <= mx_reg[W-1:ML] * MH'(my_reg[ML-1:0]);
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_m;
            rem_p[0]    <= '0;
            quo_p[0]    <= ux;
            dvs_p[0]    <= uy;
            for (int k = 3; k <= NDIV; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NDIV; g++)
        begin : g_div
            iawd_div_stage #(
                .W     (W),
                .STEPS ((g == NDIV - 1) ? LAST_STEPS : STEPS)
            ) u_stage (
                .clk     (clk),
                .en      (adv),
                .rem_in  (rem_p[g]),
                .quo_in  (quo_p[g]),
                .dvs_in  (dvs_p[g]),
                .rem_out (rem_p[g+1]),
                .quo_out (quo_p[g+1]),
                .dvs_out (dvs_p[g+1])
            );
        end
    endgenerate

    // final stage: sign fix-up and result select
    logic [W-1:0]           mag;
    logic [W-1:0]           fin;
    logic [StatusWidth-1:0] st;
    side_t                  sd;

    assign sd  = side_reg[NDIV];
    assign mag = (sd.command == CMD_DIV) ? quo_p[NDIV] : rem_p[NDIV];

    always_comb
    begin
        st  = ST_OK;
        fin = sd.other;
        if (sd.is_div)
        begin
            if (sd.zero_dvs)
            begin
                fin = '0;
                st  = (sd.command == CMD_DIV) ? ST_DIV_ZER : ST_MOD_ZER;
            end
            else
            begin
                fin = sd.neg_res ? (W'(0) - mag) : mag;
            end
        end
    end

    logic [PortWidth-1:0]   res_reg;
    logic [StatusWidth-1:0] st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= PortWidth'($signed(fin));
            st_reg  <= st;
        end
    end

    assign res.valid  = out_vld_reg;
    assign res.result = res_reg;
    assign res.status = st_reg;

endmodule
`default_nettype wire

// ----- sv/iawd_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawd_div_stage
// one registered stage of the unsigned restoring divider, STEPS bits per stage
// ----------------------------------------------------------------------------
module iawd_div_stage
    import iawd_pkg::*;
#(
    parameter int W     = IawdDataWidth,
    parameter int STEPS = 4
)
(
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] rem_in,
    input  wire logic [W-1:0] quo_in,
    input  wire logic [W-1:0] dvs_in,
    output logic      [W-1:0] rem_out,
    output logic      [W-1:0] quo_out,
    output logic      [W-1:0] dvs_out
);

    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        logic [W:0] trial;
        rem_next = rem_in;
        quo_next = quo_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {rem_next, quo_next[W-1]} - {1'b0, dvs_in};
            quo_next = {quo_next[W-2:0], ~trial[W]};
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
            end
            else
            begin
                rem_next = {rem_next[W-2:0], quo_in[W-1-i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            quo_out <= quo_next;
            dvs_out <= dvs_in;
        end
    end

endmodule
`default_nettype wire

// ----- sv/iawd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawd_checker
// port-level checks of the integer alu with divide
// ----------------------------------------------------------------------------
module iawd_checker
    import iawd_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cmd_ready,
    input wire logic                   res_valid,
    input wire logic                   res_ready,
    input wire logic [PortWidth-1:0]   res_result,
    input wire logic [StatusWidth-1:0] res_status
);

    // an output beat that waits keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_result))
        else $error("result changed while stalled");

    // status is never the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status != 2'd3)
        else $error("bad status");

    // a fault beat carries result zero
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_result == '0)
        else $error("fault result not zero");

    // input is taken whenever the output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("stalled with empty output");

endmodule

bind integer_alu_with_divide iawd_checker u_iawd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_result (res.result),
    .res_status (res.status)
);
`default_nettype wire
